// ===== rtl/core/arkf_pkg.sv =====
// shared types and constants for the angle/bias kalman filter
`timescale 1ns / 1ps
package arkf_pkg;
   localparam int CFG_IDX_BITS = 2;
   localparam int CFG_BITS = 31;
   localparam logic [CFG_IDX_BITS-1:0] REG_Q_ANGLE = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_Q_BIAS = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_R_MEASURE = 2'd2;
   localparam logic [CFG_BITS-1:0] Q_ANGLE_RESET = 31'd655;
   localparam logic [CFG_BITS-1:0] Q_BIAS_RESET = 31'd197;
   localparam logic [CFG_BITS-1:0] R_MEASURE_RESET = 31'd65536;
   localparam int ANGLE_RESET_DEG = 180;

   // multiplier operation handed to the shared unit
   typedef struct packed {
      logic start;
      logic dt_mode;   // shift by 32 (dt operand) instead of frac bits
   } arkf_mul_ctl_type;
endpackage

// ===== rtl/core/arkf_if.sv =====
// valid/ready channel interfaces for request and response items
`timescale 1ns / 1ps
interface arkf_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] rate_in;
   logic signed [31:0] measured_angle;
   logic [31:0] dt_seconds;
   modport source (output valid, rate_in, measured_angle, dt_seconds, input ready);
   modport sink (input valid, rate_in, measured_angle, dt_seconds, output ready);
endinterface

interface arkf_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] angle_estimate;
   logic signed [31:0] bias_estimate;
   modport source (output valid, angle_estimate, bias_estimate, input ready);
   modport sink (input valid, angle_estimate, bias_estimate, output ready);
endinterface

// ===== rtl/core/angle_rate_kalman_fusion.sv =====
// top level: sequencer, state and covariance registers of the angle/bias kalman filter
//
// One request takes 10 multiplies on the single shared multiplier plus two
// gain divisions on the restoring divider and an output state (the divisions
// are skipped when P00 plus R is not positive); the block is not ready while a
// request is in work and takes the next one once the response register is free.
// Configuration registers are to be written only while the block is idle; the
// block itself does not enforce it. Values are signed fixed point with FRAC_BITS
// fraction bits, saturated.
`timescale 1ns / 1ps
module angle_rate_kalman_fusion #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   arkf_req_if.sink req,
   arkf_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic [arkf_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [arkf_pkg::CFG_BITS-1:0] csr_write_data
);
   localparam int W = WORD_BITS;
   localparam int SW = W + 3;
   localparam int AW = (W > 32) ? W + 1 : 33;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = SW'(WMAX);
   localparam logic signed [SW-1:0] SMIN = SW'(WMIN);
   localparam logic signed [W+FRAC_BITS+8:0] ANGLE_RAW =
      (W+FRAC_BITS+9)'(arkf_pkg::ANGLE_RESET_DEG) <<< FRAC_BITS;
   localparam logic signed [W-1:0] ANGLE_RESET =
      (ANGLE_RAW > (W+FRAC_BITS+9)'(WMAX)) ? WMAX : W'(ANGLE_RAW);

   typedef enum logic [4:0] {
      S_IDLE, S_M_ANG, S_A_ANG, S_M_DTP, S_A_DTP, S_M_P00, S_A_P00,
      S_M_P11, S_A_P11, S_DIV0, S_DIV1, S_M_E0, S_A_E0, S_M_E1, S_A_E1,
      S_M_C0, S_A_C0, S_M_C1, S_A_C1, S_M_C2, S_A_C2, S_M_C3, S_A_C3, S_OUT
   } state_type;

   state_type st_ff, st_in;
   logic [arkf_pkg::CFG_BITS-1:0] qa_ff, qb_ff, r_ff;
   logic signed [W-1:0] ang_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [W-1:0] u_ff, y_ff, dtp_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic signed [W-1:0] k0_ff, k1_ff, e_ff;
   logic [31:0] dt_ff;
   logic signed [31:0] oa_ff, ob_ff;
   logic ovalid_ff;
   logic issued_ff, issued_in, dstart_ff, dstart_in;

   arkf_pkg::arkf_mul_ctl_type mctl;
   logic signed [AW-1:0] ma;
   logic signed [W-1:0] mb, mp, dq;
   logic mdone, ddone;
   logic signed [W+1:0] den;
   logic signed [W-1:0] qa_w, qb_w, r_w;

   function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
      if (v > SMAX) return WMAX;
      if (v < SMIN) return WMIN;
      return W'(v);
   endfunction

   function automatic logic signed [W-1:0] satc(input logic [arkf_pkg::CFG_BITS-1:0] v);
      if ((W+32)'(v) > (W+32)'(WMAX)) return WMAX;
      return W'(v);
   endfunction

   function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
      logic signed [W+32:0] x;
      x = (W+33)'(v);
      if (x > (W+33)'(WMAX)) return WMAX;
      if (x < (W+33)'(WMIN)) return WMIN;
      return W'(x);
   endfunction

   function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
      logic signed [W+32:0] x;
      x = (W+33)'(v);
      if (x > (W+33)'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (x < (W+33)'(32'sh80000000)) return 32'sh80000000;
      return 32'(x);
   endfunction

   assign qa_w = satc(qa_ff);
   assign qb_w = satc(qb_ff);
   assign r_w = satc(r_ff);
   assign den = (W+2)'(p00_ff) + (W+2)'(r_w);

   // operand select for the shared multiplier
   always_comb begin
      mctl.dt_mode = 1'b0;
      mctl.start = 1'b0;
      ma = '0;
      mb = '0;
      unique case (st_ff)
         S_M_ANG: begin
            mctl.dt_mode = 1'b1; ma = AW'($signed({1'b0, dt_ff}));
            mb = sat(SW'(u_ff) - SW'(bias_ff));
         end
         S_M_DTP: begin
            mctl.dt_mode = 1'b1; ma = AW'($signed({1'b0, dt_ff})); mb = bb_ff;
         end
         S_M_P00: begin
            mctl.dt_mode = 1'b1; ma = AW'($signed({1'b0, dt_ff}));
            mb = sat(SW'(dtp_ff) - SW'(ab_ff) - SW'(ba_ff) + SW'(qa_w));
         end
         S_M_P11: begin
            mctl.dt_mode = 1'b1; ma = AW'($signed({1'b0, dt_ff})); mb = qb_w;
         end
         S_M_E0: begin ma = AW'(k0_ff); mb = e_ff; end
         S_M_E1: begin ma = AW'(k1_ff); mb = e_ff; end
         S_M_C0: begin ma = AW'(k0_ff); mb = p00_ff; end
         S_M_C1: begin ma = AW'(k0_ff); mb = p01_ff; end
         S_M_C2: begin ma = AW'(k1_ff); mb = p00_ff; end
         S_M_C3: begin ma = AW'(k1_ff); mb = p01_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
      if (st_ff == S_M_ANG || st_ff == S_M_DTP || st_ff == S_M_P00 ||
          st_ff == S_M_P11 || st_ff == S_M_E0 || st_ff == S_M_E1 ||
          st_ff == S_M_C0 || st_ff == S_M_C1 || st_ff == S_M_C2 || st_ff == S_M_C3)
         mctl.start = !issued_ff;
   end

   // shift by 32 needs the dt operand to be the 32-bit unsigned word
   arkf_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .ctl(mctl), .a(ma), .b(mb), .done(mdone), .p(mp)
   );

   arkf_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dstart_ff),
      .num((st_ff == S_DIV0) ? p00_ff : p10_ff), .den(den),
      .done(ddone), .quo(dq)
   );

   assign req.ready = (st_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.angle_estimate = oa_ff;
   assign rsp.bias_estimate = ob_ff;

   always_comb begin
      st_in = st_ff;
      issued_in = issued_ff;
      dstart_in = 1'b0;
      if (mctl.start) issued_in = 1'b1;
      unique case (st_ff)
         S_IDLE: if (req.valid && req.ready) st_in = S_M_ANG;
         S_M_ANG: if (mdone) begin st_in = S_M_DTP; issued_in = 1'b0; end
         S_M_DTP: if (mdone) begin st_in = S_M_P00; issued_in = 1'b0; end
         S_M_P00: if (mdone) begin st_in = S_M_P11; issued_in = 1'b0; end
         S_M_P11: if (mdone) begin
            issued_in = 1'b0;
            st_in = S_DIV0;
         end
         S_DIV0: begin
            if (!issued_ff && den > 0) begin dstart_in = 1'b1; issued_in = 1'b1; end
            if (den <= 0) st_in = S_M_E0;
            else if (ddone) begin st_in = S_DIV1; issued_in = 1'b0; end
         end
         S_DIV1: begin
            if (!issued_ff) begin dstart_in = 1'b1; issued_in = 1'b1; end
            if (ddone) begin st_in = S_M_E0; issued_in = 1'b0; end
         end
         S_M_E0: if (mdone) begin st_in = S_M_E1; issued_in = 1'b0; end
         S_M_E1: if (mdone) begin st_in = S_M_C0; issued_in = 1'b0; end
         S_M_C0: if (mdone) begin st_in = S_M_C1; issued_in = 1'b0; end
         S_M_C1: if (mdone) begin st_in = S_M_C2; issued_in = 1'b0; end
         S_M_C2: if (mdone) begin st_in = S_M_C3; issued_in = 1'b0; end
         S_M_C3: if (mdone) begin st_in = S_OUT; issued_in = 1'b0; end
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         issued_ff <= 1'b0;
         dstart_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         qa_ff <= arkf_pkg::Q_ANGLE_RESET;
         qb_ff <= arkf_pkg::Q_BIAS_RESET;
         r_ff <= arkf_pkg::R_MEASURE_RESET;
         ang_ff <= ANGLE_RESET;
         bias_ff <= '0;
         aa_ff <= '0; ab_ff <= '0; ba_ff <= '0; bb_ff <= '0;
      end else begin
         st_ff <= st_in;
         issued_ff <= issued_in;
         dstart_ff <= dstart_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               arkf_pkg::REG_Q_ANGLE: qa_ff <= csr_write_data;
               arkf_pkg::REG_Q_BIAS: qb_ff <= csr_write_data;
               arkf_pkg::REG_R_MEASURE: r_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) ovalid_ff <= 1'b0;
         if (st_ff == S_IDLE && req.valid && req.ready) begin
            u_ff <= sat_in(req.rate_in);
            y_ff <= sat_in(req.measured_angle);
            dt_ff <= req.dt_seconds;
            k0_ff <= '0;
            k1_ff <= '0;
         end
         if (mdone) begin
            unique case (st_ff)
               S_M_ANG: ang_ff <= sat(SW'(ang_ff) + SW'(mp));
               S_M_DTP: begin
                  dtp_ff <= mp;
                  p01_ff <= sat(SW'(ab_ff) - SW'(mp));
                  p10_ff <= sat(SW'(ba_ff) - SW'(mp));
               end
               S_M_P00: p00_ff <= sat(SW'(aa_ff) + SW'(mp));
               S_M_P11: begin
                  p11_ff <= sat(SW'(bb_ff) + SW'(mp));
                  e_ff <= sat(SW'(y_ff) - SW'(ang_ff));
               end
               S_M_E0: ang_ff <= sat(SW'(ang_ff) + SW'(mp));
               S_M_E1: bias_ff <= sat(SW'(bias_ff) + SW'(mp));
               S_M_C0: aa_ff <= sat(SW'(p00_ff) - SW'(mp));
               S_M_C1: ab_ff <= sat(SW'(p01_ff) - SW'(mp));
               S_M_C2: ba_ff <= sat(SW'(p10_ff) - SW'(mp));
               S_M_C3: bb_ff <= sat(SW'(p11_ff) - SW'(mp));
               default: ;
            endcase
         end
         if (ddone && st_ff == S_DIV0) k0_ff <= dq;
         if (ddone && st_ff == S_DIV1) k1_ff <= dq;
         if (st_ff == S_OUT) begin
            ovalid_ff <= 1'b1;
            oa_ff <= out32(ang_ff);
            ob_ff <= out32(bias_ff);
         end
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> st_ff == S_IDLE) else $error("ready outside idle");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_OUT |=> rsp.valid) else $error("response not raised");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !req.ready) else $error("accept while busy");
   a_one_engine: assert property (@(posedge clock) disable iff (reset)
      !(mdone && ddone)) else $error("two units finish together");
endmodule

// ===== rtl/core/arkf_mul.sv =====
// shared signed multiplier: rounded, shifted and saturated product, operands and product registered
`timescale 1ns / 1ps
module arkf_mul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  arkf_pkg::arkf_mul_ctl_type ctl,
   input  logic signed [((WORD_BITS > 32) ? WORD_BITS + 1 : 33)-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic done,
   output logic signed [WORD_BITS-1:0] p
);
   // first operand also carries the 32-bit unsigned dt word
   localparam int AW = (WORD_BITS > 32) ? WORD_BITS + 1 : 33;
   localparam int PW = AW + WORD_BITS + 1;
   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic [AW-1:0] ma_ff, ma_in;
   logic [WORD_BITS-1:0] mb_ff, mb_in;
   logic neg_ff, neg_in, dtm_ff, dtm_in, busy_ff, busy_in, done_ff, done_in;
   logic signed [WORD_BITS-1:0] p_ff, p_in;
   logic [PW-1:0] prod, rnd, mag;
   logic over;

   always_comb begin
      ma_in = a[AW-1] ? (~a + 1'b1) : a;
      mb_in = b[WORD_BITS-1] ? (~b + 1'b1) : b;
      neg_in = a[AW-1] ^ b[WORD_BITS-1];
      dtm_in = ctl.dt_mode;
      busy_in = ctl.start;
      prod = PW'(ma_ff) * PW'(mb_ff);
      if (dtm_ff) begin
         rnd = prod + (PW'(1) << 31);
         mag = rnd >> 32;
      end else begin
         rnd = prod + (PW'(1) << (FRAC_BITS - 1));
         mag = rnd >> FRAC_BITS;
      end
      if (neg_ff) begin
         over = mag > PW'({1'b1, {(WORD_BITS-1){1'b0}}});
         p_in = over ? WMIN : WORD_BITS'(~mag + 1'b1);
         if (mag == 0) p_in = '0;
      end else begin
         over = mag > PW'(WMAX);
         p_in = over ? WMAX : WORD_BITS'(mag);
      end
      done_in = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      neg_ff <= neg_in;
      dtm_ff <= dtm_in;
      p_ff <= p_in;
   end

   assign done = done_ff;
   assign p = p_ff;
endmodule

// ===== rtl/core/arkf_div.sv =====
// restoring divider: (num << frac) / den, truncated and saturated, one bit a cycle
`timescale 1ns / 1ps
module arkf_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [WORD_BITS-1:0] num,
   input  logic signed [WORD_BITS+1:0] den,
   output logic done,
   output logic signed [WORD_BITS-1:0] quo
);
   localparam int NB = WORD_BITS + FRAC_BITS;
   localparam int CW = $clog2(NB + 1);
   localparam int RW = WORD_BITS + 3;
   localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   logic [NB-1:0] n_ff, n_in, q_ff, q_in;
   logic [RW-1:0] rem_ff, rem_in, d_ff, d_in, trial;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic signed [WORD_BITS-1:0] quo_ff, quo_in;

   always_comb begin
      n_in = n_ff; q_in = q_ff; rem_in = rem_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff;
      done_in = 1'b0; quo_in = quo_ff;
      trial = {rem_ff[RW-2:0], n_ff[NB-1]};
      if (start) begin
         n_in = {(num[WORD_BITS-1] ? WORD_BITS'(~num + 1'b1) : WORD_BITS'(num)),
                 {FRAC_BITS{1'b0}}};
         d_in = RW'(den);
         rem_in = '0;
         q_in = '0;
         neg_in = num[WORD_BITS-1];
         cnt_in = CW'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (trial >= d_ff) begin
            rem_in = trial - d_ff;
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff)
               quo_in = (q_in > NB'({1'b1, {(WORD_BITS-1){1'b0}}})) ? WMIN
                        : WORD_BITS'(~q_in + 1'b1);
            else
               quo_in = (q_in > NB'(WMAX)) ? WMAX : WORD_BITS'(q_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in; q_ff <= q_in; rem_ff <= rem_in; d_ff <= d_in;
      neg_ff <= neg_in; quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule
